// ===== rtl/bpa_pkg.sv =====
// Buddy page allocator package: field widths, defaults, register indexes,
// controller states, datapath micro-ops and the command/status structs.
// No dependencies.
package bpa_pkg;
	localparam int PageBitsDef = 16;
	localparam int OrderMaxDef = 10;
	localparam int PageShift   = 12;
	localparam int AddrW       = 29;
	localparam int KindW       = 2;
	localparam int PageW       = 16;
	localparam int CountW      = 17;
	localparam int OrderW      = 4;
	localparam int HdrW        = 12;
	localparam int CfgIdxW     = 2;

	localparam logic [OrderW-1:0]  TopOrderRst = 4'd10;
	localparam logic [HdrW-1:0]    HdrRst      = 12'd16;
	localparam logic [CfgIdxW-1:0] CfgTopOrder = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgHdrBytes = 2'd1;

	typedef enum logic [KindW-1:0] {
		KIND_ADD,
		KIND_ALLOC,
		KIND_FREE,
		KIND_NONE
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD,
		S_AL_READ,
		S_AL_POP,
		S_AL_SPLIT,
		S_FR_CHECK,
		S_FR_WALK,
		S_FR_NEXT,
		S_FR_UNLINK,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_ADD_PUSH,
		OP_AL_FAIL,
		OP_AL_READ,
		OP_AL_POP,
		OP_AL_SPLIT,
		OP_AL_FIN,
		OP_WALK_START,
		OP_WALK_STEP,
		OP_READ_CUR,
		OP_WALK_LOAD,
		OP_UNLINK,
		OP_FR_PUSH,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  add_more;
		logic  al_found;
		logic  al_split;
		logic  free_ok;
		logic  merge_ok;
		logic  walk_end;
		logic  walk_hit;
		logic  out_free;
	} dp_stat_t;
endpackage

// ===== rtl/bpa_ifs.sv =====
// Request, response and configuration channel interfaces (valid/ready).
// Depends on bpa_pkg.
interface bpa_req_if;
	import bpa_pkg::*;
	logic                valid;
	logic                ready;
	logic [KindW-1:0]    kind;
	logic [PageW-1:0]    page;
	logic [CountW-1:0]   page_count;
	logic [OrderW-1:0]   order;
	logic                raw;
	modport source(output valid, kind, page, page_count, order, raw, input ready);
	modport sink(input valid, kind, page, page_count, order, raw, output ready);
endinterface

interface bpa_rsp_if;
	import bpa_pkg::*;
	logic             valid;
	logic             ready;
	logic             ok;
	logic [AddrW-1:0] address;
	modport source(output valid, ok, address, input ready);
	modport sink(input valid, ok, address, output ready);
endinterface

interface bpa_cfg_if;
	import bpa_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [HdrW-1:0]    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/bpa_datapath.sv =====
// Buddy allocator datapath: list heads, link memory, work registers,
// config registers and response register. Driven by bpa_ctrl micro-ops.
// Depends on bpa_pkg.
module bpa_datapath #(
	parameter int PAGE_BITS = bpa_pkg::PageBitsDef,
	parameter int ORDER_MAX = bpa_pkg::OrderMaxDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [bpa_pkg::KindW-1:0]   req_kind,
	input  logic [bpa_pkg::PageW-1:0]   req_page,
	input  logic [bpa_pkg::CountW-1:0]  req_page_count,
	input  logic [bpa_pkg::OrderW-1:0]  req_order,
	input  logic                        req_raw,
	input  logic                        cfg_valid,
	input  logic [bpa_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bpa_pkg::HdrW-1:0]    cfg_data,
	input  logic                        rsp_ready,
	output logic                        rsp_valid,
	output logic                        rsp_ok,
	output logic [bpa_pkg::AddrW-1:0]   rsp_address,
	input  bpa_pkg::dp_cmd_t            cmd,
	output bpa_pkg::dp_stat_t           stat
);
	import bpa_pkg::*;

	localparam int PW = PAGE_BITS;
	localparam int OW = (ORDER_MAX < 2) ? 1 : $clog2(ORDER_MAX + 1);
	localparam int WW = (((PW + 1) > CountW) ? (PW + 1) : CountW) + 1;
	localparam logic [PW:0]        NPagesW   = {1'b1, {PW{1'b0}}};
	localparam logic [OrderW-1:0]  OrderMaxW = OrderW'(ORDER_MAX);
	localparam logic [5:0]         PageBitsW = 6'(PAGE_BITS);

	logic [PW:0]       heads_q [ORDER_MAX+1];
	logic [PW:0]       links [2**PW];
	logic [PW:0]       rd_q;

	kind_t             kind_q;
	logic              raw_q;
	logic              inr_q;
	logic [OrderW-1:0] ord_q;
	logic [OW-1:0]     x_q;
	logic [PW:0]       wpg_q;
	logic [PW:0]       end_q;
	logic [PW:0]       cur_q;
	logic [PW-1:0]     prev_q;
	logic              has_prev_q;
	logic [PW+1:0]     steps_q;
	logic [OrderW-1:0] top_q;
	logic [HdrW-1:0]   hdr_q;
	logic              ok_q;
	logic [AddrW-1:0]  addr_q;
	logic              rsp_valid_q;
	logic              rsp_ok_q;
	logic [AddrW-1:0]  rsp_addr_q;

	logic [OrderW-1:0] top_eff;
	logic [WW-1:0]     pg_in_w, cnt_w, npg_w, end_w;
	logic              in_range;
	logic [ORDER_MAX:0] cand;
	logic [OW-1:0]     add_ord;
	logic [PW:0]       add_sz;
	logic [ORDER_MAX:0] al_hit;
	logic [OW-1:0]     al_x;
	logic [OW-1:0]     xm1;
	logic [PW:0]       split_sz;
	logic [PW-1:0]     split_pg;
	logic [PW+11:0]    al_addr;
	logic [OW-1:0]     ord_idx;
	logic [PW:0]       sz_ord;
	logic [PW:0]       buddy_w;
	logic              we, re;
	logic [PW-1:0]     waddr, raddr;
	logic [PW:0]       wdata;

	assign top_eff = (top_q > OrderMaxW) ? OrderMaxW : top_q;

	assign pg_in_w  = WW'(req_page);
	assign cnt_w    = WW'(req_page_count);
	assign npg_w    = WW'(NPagesW);
	assign in_range = pg_in_w < npg_w;
	assign end_w    = (cnt_w > (npg_w - pg_in_w)) ? npg_w : (pg_in_w + cnt_w);

	for (genvar o = 0; o <= ORDER_MAX; o++) begin : g_ord
		if (o == 0) begin : g_base
			assign cand[o] = 1'b1;
		end else if (o > PW) begin : g_big
			assign cand[o] = 1'b0;
		end else begin : g_fit
			localparam logic [PW:0] Sz = {{PW{1'b0}}, 1'b1} << o;
			assign cand[o] = (OrderW'(o) <= top_eff)
				&& ((wpg_q & (Sz - 1'b1)) == '0)
				&& ((end_q - wpg_q) >= Sz);
		end
		assign al_hit[o] = heads_q[o][PW] && (OrderW'(o) >= ord_q)
			&& (OrderW'(o) <= top_eff);
	end

	always_comb begin
		add_ord = '0;
		for (int i = 1; i <= ORDER_MAX; i++) begin
			if (cand[i]) add_ord = OW'(i);
		end
	end

	always_comb begin
		al_x = '0;
		for (int i = ORDER_MAX; i >= 0; i--) begin
			if (al_hit[i]) al_x = OW'(i);
		end
	end

	assign add_sz   = {{PW{1'b0}}, 1'b1} << add_ord;
	assign xm1      = x_q - 1'b1;
	assign split_sz = {{PW{1'b0}}, 1'b1} << xm1;
	assign split_pg = wpg_q[PW-1:0] + split_sz[PW-1:0];
	assign al_addr  = {wpg_q[PW-1:0], {PageShift{1'b0}}}
		+ (raw_q ? '0 : (PW+12)'(hdr_q));
	assign ord_idx  = ord_q[OW-1:0];
	assign sz_ord   = {{PW{1'b0}}, 1'b1} << ord_q;
	assign buddy_w  = wpg_q ^ sz_ord;

	assign stat.kind     = kind_q;
	assign stat.add_more = wpg_q < end_q;
	assign stat.al_found = |al_hit;
	assign stat.al_split = OrderW'(x_q) > ord_q;
	assign stat.free_ok  = inr_q && (ord_q <= OrderMaxW) && ({2'b0, ord_q} <= PageBitsW)
		&& (sz_ord <= (NPagesW - wpg_q));
	assign stat.merge_ok = (ord_q < top_eff) && ({2'b0, ord_q} < PageBitsW)
		&& ((buddy_w + sz_ord) <= NPagesW);
	assign stat.walk_end = !cur_q[PW] || (steps_q > {1'b0, NPagesW});
	assign stat.walk_hit = cur_q[PW-1:0] == buddy_w[PW-1:0];
	assign stat.out_free = !rsp_valid_q || rsp_ready;

	// link memory ports
	always_comb begin
		we    = 1'b0;
		waddr = wpg_q[PW-1:0];
		wdata = heads_q[ord_idx];
		re    = 1'b0;
		raddr = cur_q[PW-1:0];
		case (cmd.op)
			OP_ADD_PUSH: begin
				we    = 1'b1;
				wdata = heads_q[add_ord];
			end
			OP_AL_READ: begin
				re    = 1'b1;
				raddr = heads_q[al_x][PW-1:0];
			end
			OP_AL_SPLIT: begin
				we    = 1'b1;
				waddr = split_pg;
				wdata = heads_q[xm1];
			end
			OP_WALK_STEP, OP_READ_CUR: begin
				re = 1'b1;
			end
			OP_UNLINK: begin
				we    = has_prev_q;
				waddr = prev_q;
				wdata = rd_q;
			end
			OP_FR_PUSH: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) links[waddr] <= wdata;
		if (re) rd_q <= links[raddr];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q <= kind_t'(req_kind);
				raw_q  <= req_raw;
				ord_q  <= req_order;
				inr_q  <= in_range;
				wpg_q  <= pg_in_w[PW:0];
				end_q  <= in_range ? end_w[PW:0] : pg_in_w[PW:0];
				addr_q <= '0;
			end
			OP_ADD_PUSH: wpg_q <= wpg_q + add_sz;
			OP_AL_READ: begin
				x_q   <= al_x;
				wpg_q <= {1'b0, heads_q[al_x][PW-1:0]};
			end
			OP_AL_SPLIT: x_q <= xm1;
			OP_AL_FIN: addr_q <= AddrW'(al_addr);
			OP_WALK_START: begin
				cur_q      <= heads_q[ord_idx];
				has_prev_q <= 1'b0;
				steps_q    <= '0;
			end
			OP_WALK_STEP: begin
				prev_q     <= cur_q[PW-1:0];
				has_prev_q <= 1'b1;
				steps_q    <= steps_q + 1'b1;
			end
			OP_WALK_LOAD: cur_q <= rd_q;
			OP_UNLINK: begin
				if (buddy_w < wpg_q) wpg_q <= buddy_w;
				ord_q <= ord_q + 1'b1;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ORDER_MAX; i++) heads_q[i] <= '0;
			ok_q        <= 1'b1;
			top_q       <= TopOrderRst;
			hdr_q       <= HdrRst;
			rsp_valid_q <= 1'b0;
			rsp_ok_q    <= 1'b0;
			rsp_addr_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CfgTopOrder: top_q <= cfg_data[OrderW-1:0];
					CfgHdrBytes: hdr_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_LOAD:     ok_q <= 1'b1;
				OP_AL_FAIL:  ok_q <= 1'b0;
				OP_ADD_PUSH: heads_q[add_ord] <= {1'b1, wpg_q[PW-1:0]};
				OP_AL_POP:   heads_q[x_q] <= rd_q;
				OP_AL_SPLIT: heads_q[xm1] <= {1'b1, split_pg};
				OP_UNLINK:   if (!has_prev_q) heads_q[ord_idx] <= rd_q;
				OP_FR_PUSH:  heads_q[ord_idx] <= {1'b1, wpg_q[PW-1:0]};
				default: ;
			endcase
			if (cmd.op == OP_OUT_LOAD) begin
				rsp_valid_q <= 1'b1;
				rsp_ok_q    <= ok_q;
				rsp_addr_q  <= addr_q;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rsp_ok      = rsp_ok_q;
	assign rsp_address = rsp_addr_q;
endmodule

// ===== rtl/bpa_ctrl.sv =====
// Buddy allocator controller: state machine sequencing datapath micro-ops.
// Depends on bpa_pkg.
module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bpa_pkg::dp_stat_t  stat,
	output bpa_pkg::dp_cmd_t   cmd
);
	import bpa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NOP;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.kind)
					KIND_ADD: state_d = S_ADD;
					KIND_ALLOC: begin
						if (stat.al_found) begin
							state_d = S_AL_READ;
						end else begin
							cmd.op  = OP_AL_FAIL;
							state_d = S_DONE;
						end
					end
					KIND_FREE: state_d = stat.free_ok ? S_FR_CHECK : S_DONE;
					default: state_d = S_DONE;
				endcase
			end
			S_ADD: begin
				if (stat.add_more) begin
					cmd.op = OP_ADD_PUSH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_AL_READ: begin
				cmd.op  = OP_AL_READ;
				state_d = S_AL_POP;
			end
			S_AL_POP: begin
				cmd.op  = OP_AL_POP;
				state_d = S_AL_SPLIT;
			end
			S_AL_SPLIT: begin
				if (stat.al_split) begin
					cmd.op = OP_AL_SPLIT;
				end else begin
					cmd.op  = OP_AL_FIN;
					state_d = S_DONE;
				end
			end
			S_FR_CHECK: begin
				if (stat.merge_ok) begin
					cmd.op  = OP_WALK_START;
					state_d = S_FR_WALK;
				end else begin
					cmd.op  = OP_FR_PUSH;
					state_d = S_DONE;
				end
			end
			S_FR_WALK: begin
				if (stat.walk_end) begin
					cmd.op  = OP_FR_PUSH;
					state_d = S_DONE;
				end else if (stat.walk_hit) begin
					cmd.op  = OP_READ_CUR;
					state_d = S_FR_UNLINK;
				end else begin
					cmd.op  = OP_WALK_STEP;
					state_d = S_FR_NEXT;
				end
			end
			S_FR_NEXT: begin
				cmd.op  = OP_WALK_LOAD;
				state_d = S_FR_WALK;
			end
			S_FR_UNLINK: begin
				cmd.op  = OP_UNLINK;
				state_d = S_FR_CHECK;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== rtl/buddy_page_allocator_top.sv =====
// Buddy page allocator over 4 KB pages, one LIFO free list per order. One
// request at a time, each giving one response. Add region pushes the largest
// aligned block that fits, repeatedly; allocate pops the lowest non-empty
// order at or above the one asked and splits down an order at a time; free
// walks the buddy's list through the link memory's single registered read
// port and merges while the buddy is found. The response register lets the
// next request in while a response waits. The link memory needs no clearing
// pass after reset. Depends on bpa_pkg, bpa_ifs, bpa_ctrl and bpa_datapath.
module buddy_page_allocator_top #(
	parameter int PAGE_BITS = bpa_pkg::PageBitsDef,
	parameter int ORDER_MAX = bpa_pkg::OrderMaxDef
) (
	input logic      clk,
	input logic      arst_n,
	bpa_req_if.sink  req,
	bpa_rsp_if.source rsp,
	bpa_cfg_if.sink  cfg
);
	import bpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg.ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpa_datapath #(
		.PAGE_BITS (PAGE_BITS),
		.ORDER_MAX (ORDER_MAX)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_kind       (req.kind),
		.req_page       (req.page),
		.req_page_count (req.page_count),
		.req_order      (req.order),
		.req_raw        (req.raw),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_ok         (rsp.ok),
		.rsp_address    (rsp.address),
		.cmd            (cmd),
		.stat           (stat)
	);
endmodule

// ===== rtl/bpa_checker.sv =====
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg and buddy_page_allocator_top.
module bpa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       rsp_ok,
	input logic [bpa_pkg::AddrW-1:0]  rsp_address,
	input logic                       cfg_ready
);
	import bpa_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address) && $stable(rsp_ok))
		else $error("response changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_address == '0)
		else $error("failed allocation carries an address");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in work");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");
endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_ok      (rsp.ok),
	.rsp_address (rsp.address),
	.cfg_ready   (cfg.ready)
);

// ===== tb/bpa_alloc_checker.sv =====
`timescale 1ns / 100ps
// Watches the request, response and configuration channels of the buddy page allocator,
// keeps its own copy of the free lists and compares every response with the prediction.
// Depends on bpa_pkg and bpa_ifs.
module bpa_alloc_checker (
	input  logic clk,
	input  logic arst_n,
	bpa_req_if   req,
	bpa_rsp_if   rsp,
	bpa_cfg_if   cfg,
	output int   fails,
	output int   pending
);
	import bpa_pkg::*;

	localparam int unsigned NPages = 1 << PageBitsDef;

	typedef struct packed {
		logic             ok;
		logic [AddrW-1:0] address;
	} alloc_result_t;

	alloc_result_t          due_q[$];
	logic [PageW:0]         heads[0:OrderMaxDef];
	logic [PageW:0]         links[0:NPages-1];
	logic [OrderW-1:0]      top_order;
	logic [HdrW-1:0]        hdr_bytes;

	assign pending = due_q.size();

	function automatic int unsigned eff_top();
		return (top_order > OrderMaxDef) ? OrderMaxDef : top_order;
	endfunction

	function automatic void push_blk(int unsigned pg, int unsigned o);
		links[pg % NPages] = heads[o];
		heads[o] = {1'b1, 16'(pg)};
	endfunction

	function automatic bit unlink_blk(int unsigned o, int unsigned target);
		logic [PageW:0] cur;
		int unsigned    prev;
		int unsigned    pg;
		bit             has_prev;
		int unsigned    steps;
		cur = heads[o];
		prev = 0;
		has_prev = 0;
		steps = 0;
		while (cur[PageW] && steps <= NPages) begin
			pg = cur[PageW-1:0];
			if (pg == target) begin
				if (has_prev)
					links[prev] = links[pg];
				else
					heads[o] = links[pg];
				return 1;
			end
			prev = pg;
			has_prev = 1;
			cur = links[pg];
			steps++;
		end
		return 0;
	endfunction

	function automatic void add_region(int unsigned pg, int unsigned cnt);
		int unsigned last;
		int unsigned o;
		if (pg >= NPages)
			return;
		last = (cnt > NPages - pg) ? NPages : pg + cnt;
		while (pg < last) begin
			o = eff_top();
			while (o > 0) begin
				if ((pg & ((1 << o) - 1)) == 0 && last - pg >= (1 << o))
					break;
				o--;
			end
			push_blk(pg, o);
			pg += 1 << o;
		end
	endfunction

	function automatic bit take_block(int unsigned o, output int unsigned got);
		int unsigned x;
		int unsigned pg;
		got = 0;
		for (x = o; x <= eff_top(); x++) begin
			if (!heads[x][PageW])
				continue;
			pg = heads[x][PageW-1:0];
			heads[x] = links[pg];
			while (x > o) begin
				x--;
				push_blk(pg + (1 << x), x);
			end
			got = pg;
			return 1;
		end
		return 0;
	endfunction

	function automatic void release_block(int unsigned pg, int unsigned o);
		int unsigned buddy;
		int unsigned sz;
		if (o > OrderMaxDef || pg >= NPages || o > PageBitsDef)
			return;
		if ((1 << o) > NPages - pg)
			return;
		while (o < eff_top()) begin
			sz = 1 << o;
			if (sz >= NPages)
				break;
			buddy = pg ^ sz;
			if (buddy >= NPages || sz > NPages - buddy)
				break;
			if (!unlink_blk(o, buddy))
				break;
			if (buddy < pg)
				pg = buddy;
			o++;
		end
		push_blk(pg, o);
	endfunction

	function automatic alloc_result_t predict(kind_t k, int unsigned pg, int unsigned cnt,
			int unsigned o, bit raw);
		alloc_result_t r;
		int unsigned   got;
		logic [31:0]   a;
		r.ok = 1'b1;
		r.address = '0;
		case (k)
			KIND_ADD: add_region(pg, cnt);
			KIND_ALLOC: begin
				if (take_block(o, got)) begin
					a = (got << PageShift) + (raw ? 0 : hdr_bytes);
					r.address = a[AddrW-1:0];
				end else begin
					r.ok = 1'b0;
				end
			end
			KIND_FREE: release_block(pg, o);
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			for (int i = 0; i <= OrderMaxDef; i++)
				heads[i] = '0;
			due_q.delete();
			top_order = TopOrderRst;
			hdr_bytes = HdrRst;
			fails = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CfgTopOrder)
					top_order = cfg.data[OrderW-1:0];
				else if (cfg.index == CfgHdrBytes)
					hdr_bytes = cfg.data;
			end
			if (req.valid && req.ready)
				due_q.push_back(predict(kind_t'(req.kind), req.page, req.page_count,
					req.order, req.raw));
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					$error("unexpected response transfer ok=%0d address=%h",
						rsp.ok, rsp.address);
					fails++;
				end else begin
					want = due_q.pop_front();
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, rsp.ok);
						fails++;
					end
					if (rsp.address !== want.address) begin
						$error("address: expected %h, got %h", want.address, rsp.address);
						fails++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb_buddy_page_allocator_top.sv =====
`timescale 1ns / 100ps
// Top of the buddy page allocator testbench: clock, reset, configuration phases and
// request/response traffic. Depends on bpa_pkg, bpa_ifs, the allocator and bpa_alloc_checker.
module tb_buddy_page_allocator_top;
	import bpa_pkg::*;

	// a free on a cyclic list walks 2^16+1 nodes
	localparam int CycleLimit = 2_000_000_000;

	typedef struct {
		kind_t       kind;
		int unsigned order;
		bit          raw;
	} req_meta_t;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	bit   idle_en;
	bit   stall_go;
	logic [HdrW-1:0] cur_hdr;

	req_meta_t   meta_q[$];
	int unsigned live_pg[$];
	int unsigned live_ord[$];

	bpa_req_if req_ch();
	bpa_rsp_if rsp_ch();
	bpa_cfg_if cfg_ch();

	buddy_page_allocator_top uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
	);

	bpa_alloc_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("buddy_page_allocator_top: mismatch");
		$finish;
	end

	// response-side ready, with one long hold-off on request
	initial begin
		rsp_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (stall_go) begin
				stall_go = 0;
				rsp_ch.ready = 0;
				repeat (400) @(negedge clk);
			end
			rsp_ch.ready = idle_en ? ($urandom_range(99) >= 38) : 1'b1;
		end
	end

	// track granted blocks so frees name real ones
	always @(posedge clk) begin
		req_meta_t m;
		if (req_ch.valid && req_ch.ready)
			meta_q.push_back('{kind_t'(req_ch.kind), req_ch.order, req_ch.raw});
		if (rsp_ch.valid && rsp_ch.ready && meta_q.size() > 0) begin
			m = meta_q.pop_front();
			if (m.kind == KIND_ALLOC && rsp_ch.ok) begin
				live_pg.push_back((rsp_ch.address - (m.raw ? 0 : cur_hdr)) >> PageShift);
				live_ord.push_back(m.order);
			end
		end
	end

	task automatic send(kind_t k, int unsigned pg, int unsigned cnt, int unsigned o, bit raw);
		if (idle_en && $urandom_range(99) < 38) begin
			req_ch.valid = 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_ch.kind = k;
		req_ch.page = pg;
		req_ch.page_count = cnt;
		req_ch.order = o;
		req_ch.raw = raw;
		req_ch.valid = 1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [HdrW-1:0] val);
		cfg_ch.index = idx;
		cfg_ch.data = val;
		cfg_ch.valid = 1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 0;
	endtask

	task automatic drain();
		req_ch.valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic random_item(int unsigned top);
		int unsigned r;
		int unsigned i;
		int unsigned o;
		r = $urandom_range(99);
		if (r < 40 && live_pg.size() > 0) begin
			i = $urandom_range(live_pg.size() - 1);
			send(KIND_FREE, live_pg[i], $urandom_range(17'h1FFFF), live_ord[i], $urandom_range(1));
			live_pg.delete(i);
			live_ord.delete(i);
		end else if (r < 87) begin
			o = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(top > 10 ? 10 : top);
			send(KIND_ALLOC, $urandom_range(16'hFFFF), $urandom_range(17'h1FFFF), o,
				$urandom_range(1));
		end else begin
			case ($urandom_range(3))
				0: send(KIND_NONE, $urandom_range(16'hFFFF), $urandom_range(17'h1FFFF),
					$urandom_range(15), $urandom_range(1));
				1: send(KIND_FREE, $urandom_range(16'hFFFF), $urandom_range(17'h1FFFF),
					$urandom_range(11, 15), $urandom_range(1));
				2: begin
					o = $urandom_range(1, 10);
					send(KIND_FREE, 16'hFFFF - $urandom_range((1 << o) - 2), 0, o, 0);
				end
				default: send(KIND_ADD, $urandom_range(16'hFFFF), 0, $urandom_range(15),
					$urandom_range(1));
			endcase
		end
	endtask

	initial begin
		int unsigned tops[5];
		logic [HdrW-1:0] hdrs[5];
		tops = '{10, 0, 15, 5, 3};
		hdrs = '{12'd0, 12'd4095, 12'd123, 12'd16, 12'($urandom_range(4095))};
		arst_n = 0;
		idle_en = 1;
		stall_go = 0;
		cur_hdr = HdrRst;
		req_ch.valid = 0;
		req_ch.kind = KIND_NONE;
		req_ch.page = 0;
		req_ch.page_count = 0;
		req_ch.order = 0;
		req_ch.raw = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = CfgTopOrder;
		cfg_ch.data = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CfgTopOrder, tops[ph]);
			write_reg(CfgHdrBytes, hdrs[ph]);
			cur_hdr = hdrs[ph];
			idle_en = (ph != 1);
			if (ph == 0) begin
				send(KIND_ADD, 0, 32768, 0, 0);
				send(KIND_ADD, 16'hFFFF, 17'h10000, 0, 0);
				send(KIND_ADD, 40000, 0, 0, 0);
				send(KIND_ADD, 32773, 100, 0, 0);
				send(KIND_ALLOC, 0, 0, 0, 0);
				send(KIND_ALLOC, 0, 0, 10, 1);
				send(KIND_ALLOC, 0, 0, 3, 0);
				send(KIND_ALLOC, 0, 0, 11, 0);
				send(KIND_ALLOC, 16'hFFFF, 17'h1FFFF, 15, 1);
				send(KIND_FREE, 0, 0, 15, 0);
				send(KIND_FREE, 16'hFFFF, 0, 1, 0);
				send(KIND_NONE, 16'hFFFF, 17'h10000, 15, 1);
				send(KIND_NONE, 16'h5555, 17'h0FFFF, 4'hA, 0);
				send(KIND_FREE, 33, 0, 1, 0);
				// same top-order block freed twice
				send(KIND_FREE, 49152, 0, 10, 0);
				send(KIND_FREE, 49152, 0, 10, 0);
				send(KIND_FREE, 50688, 0, 9, 0);
				send(KIND_ALLOC, 0, 0, 0, 1);
				send(KIND_ALLOC, 0, 0, 1, 0);
				drain();
				write_reg(CfgTopOrder, 4);
				send(KIND_FREE, 50688, 0, 9, 1);
				send(KIND_ALLOC, 0, 0, 5, 0);
				drain();
				write_reg(CfgTopOrder, tops[ph]);
			end
			if (ph == 2)
				stall_go = 1;
			repeat (90) random_item(tops[ph]);
			drain();
		end

		if (fails == 0) begin
			$display("buddy_page_allocator_top: match");
		end else begin
			$display("buddy_page_allocator_top: mismatch");
		end
		$finish;
	end
endmodule
